// File: rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the lsb-first bit packer: code and byte
// widths, the packed job that travels from the front to the back, and the
// depth of the job queue between them.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned MAX_CODE_BITS = 64;
  localparam int unsigned COUNT_BITS    = 32;
  localparam int unsigned TOTAL_W       = 32;
  localparam int unsigned BYTE_BITS     = 8;
  localparam int unsigned NCOUNT_W      = 7;
  localparam int unsigned PEND_W        = BYTE_BITS - 1;
  localparam int unsigned PCNT_W        = $clog2(BYTE_BITS);
  localparam int unsigned DATA_W        = VALUE_W + BYTE_BITS;
  localparam int unsigned NBYTES_W      = $clog2(DATA_W / BYTE_BITS + 1);
  localparam int unsigned OBITS_W       = 4;
  localparam int unsigned SHIFT_W       = NBYTES_W + PCNT_W;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QUEUE_AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic [NBYTES_W-1:0] nbytes;
    logic [OBITS_W-1:0]  last_bits;
    logic [TOTAL_W-1:0]  total;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_beat_t;

endpackage

// File: rtl/lbp_front.sv
// ----------------------------------------------------------------------------
// lbp_front
// Accepts codes, merges them with the waiting bits, updates the saturating
// bit counter and hands one job per byte-producing code to the queue.
// ----------------------------------------------------------------------------
module lbp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            q_full_i,
  input  logic [lbp_pkg::VALUE_W-1:0]     value_i,
  input  logic [lbp_pkg::NCOUNT_W-1:0]    bit_count_i,
  input  logic                            finish_i,
  output lbp_pkg::job_beat_t              job_o
);

  logic [lbp_pkg::PEND_W-1:0]     pend_bits_q, pend_bits_d;
  logic [lbp_pkg::PCNT_W-1:0]     pend_cnt_q, pend_cnt_d;
  logic [lbp_pkg::COUNT_BITS-1:0] written_q, written_d;

  logic                           accept;
  logic [lbp_pkg::NCOUNT_W-1:0]   n_c;
  logic [lbp_pkg::VALUE_W-1:0]    code_mask;
  logic [lbp_pkg::DATA_W-1:0]     merged;
  logic [lbp_pkg::DATA_W-1:0]     rest;
  logic [lbp_pkg::NCOUNT_W-1:0]   tot;
  logic [lbp_pkg::NBYTES_W-1:0]   full_bytes;
  logic [lbp_pkg::PCNT_W-1:0]     rem;
  logic                           flush;
  logic [lbp_pkg::COUNT_BITS:0]   sum;

  assign accept = push_i && !q_full_i;

  always_comb begin
    if (bit_count_i > lbp_pkg::NCOUNT_W'(lbp_pkg::MAX_CODE_BITS)) begin
      n_c = lbp_pkg::NCOUNT_W'(lbp_pkg::MAX_CODE_BITS);
    end else begin
      n_c = bit_count_i;
    end
    if (n_c >= lbp_pkg::NCOUNT_W'(lbp_pkg::VALUE_W)) begin
      code_mask = '1;
    end else begin
      code_mask = (lbp_pkg::VALUE_W'(1) << n_c) - lbp_pkg::VALUE_W'(1);
    end
    merged = (lbp_pkg::DATA_W'(value_i & code_mask) << pend_cnt_q)
           | lbp_pkg::DATA_W'(pend_bits_q);
    tot        = n_c + lbp_pkg::NCOUNT_W'(pend_cnt_q);
    full_bytes = lbp_pkg::NBYTES_W'(tot >> lbp_pkg::PCNT_W);
    rem        = tot[lbp_pkg::PCNT_W-1:0];
    flush      = finish_i && (rem != '0);
    rest       = merged >> {full_bytes, {lbp_pkg::PCNT_W{1'b0}}};

    if (finish_i) begin
      pend_bits_d = '0;
      pend_cnt_d  = '0;
    end else begin
      pend_bits_d = rest[lbp_pkg::PEND_W-1:0];
      pend_cnt_d  = rem;
    end

    sum = {1'b0, written_q} + (lbp_pkg::COUNT_BITS + 1)'(n_c);
    if (sum[lbp_pkg::COUNT_BITS]) begin
      written_d = '1;
    end else begin
      written_d = sum[lbp_pkg::COUNT_BITS-1:0];
    end

    job_o.valid         = accept && ((full_bytes != '0) || flush);
    job_o.job.data      = merged;
    job_o.job.nbytes    = full_bytes + lbp_pkg::NBYTES_W'(flush);
    job_o.job.last_bits = flush ? lbp_pkg::OBITS_W'(rem)
                                : lbp_pkg::OBITS_W'(lbp_pkg::BYTE_BITS);
    job_o.job.total     = lbp_pkg::TOTAL_W'(written_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      written_q   <= '0;
    end else if (accept) begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      written_q   <= written_d;
    end
  end

  // waiting bits above the waiting count are always zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_bits_q >> pend_cnt_q) == '0)
    else $error("stale bits above pending count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && finish_i |=> (pend_cnt_q == '0))
    else $error("pending bits left after flush");

endmodule

// File: rtl/lbp_queue.sv
// ----------------------------------------------------------------------------
// lbp_queue
// Short job queue between the packing front and the byte serializer.
// ----------------------------------------------------------------------------
module lbp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lbp_pkg::job_beat_t wr_i,
  output logic               full_o,
  input  logic               rd_i,
  output lbp_pkg::job_beat_t head_o
);

  lbp_pkg::job_t                mem [lbp_pkg::QUEUE_DEPTH];
  logic [lbp_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [lbp_pkg::QUEUE_CW-1:0] cnt_q;
  logic                         do_wr, do_rd;

  assign full_o = (cnt_q == lbp_pkg::QUEUE_CW'(lbp_pkg::QUEUE_DEPTH));
  assign do_wr  = wr_i.valid && !full_o;
  assign do_rd  = rd_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= wr_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == lbp_pkg::QUEUE_AW'(lbp_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + lbp_pkg::QUEUE_AW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == lbp_pkg::QUEUE_AW'(lbp_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + lbp_pkg::QUEUE_AW'(1);
      end
      cnt_q <= cnt_q + lbp_pkg::QUEUE_CW'(do_wr) - lbp_pkg::QUEUE_CW'(do_rd);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lbp_pkg::QUEUE_CW'(lbp_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

// File: rtl/lbp_back.sv
// ----------------------------------------------------------------------------
// lbp_back
// Walks the bytes of the job at the queue head into the result register,
// one per cycle while the result register is empty or being popped.
// ----------------------------------------------------------------------------
module lbp_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lbp_pkg::job_beat_t             head_i,
  output logic                           q_rd_o,
  input  logic                           pop,
  output logic                           empty,
  output logic [lbp_pkg::BYTE_BITS-1:0]  out_byte_o,
  output logic [lbp_pkg::OBITS_W-1:0]    out_bits_o,
  output logic                           run_last_o,
  output logic [lbp_pkg::TOTAL_W-1:0]    total_bits_o
);

  logic [lbp_pkg::NBYTES_W-1:0] idx_q;
  logic                         out_v_q;
  logic                         advance;
  logic                         is_last;

  assign advance = head_i.valid && (!out_v_q || pop);
  assign is_last = (idx_q == head_i.job.nbytes - lbp_pkg::NBYTES_W'(1));
  assign q_rd_o  = advance && is_last;
  assign empty   = !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (advance) begin
        out_v_q <= 1'b1;
        idx_q   <= is_last ? '0 : idx_q + lbp_pkg::NBYTES_W'(1);
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_o   <= head_i.job.data[{idx_q, {lbp_pkg::PCNT_W{1'b0}}} +: lbp_pkg::BYTE_BITS];
      out_bits_o   <= is_last ? head_i.job.last_bits
                              : lbp_pkg::OBITS_W'(lbp_pkg::BYTE_BITS);
      run_last_o   <= is_last;
      total_bits_o <= head_i.job.total;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid |-> (idx_q < head_i.job.nbytes))
    else $error("byte index past end of job");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_i.valid |-> (idx_q == '0))
    else $error("byte index not cleared between jobs");

endmodule

// File: rtl/lsb_first_bit_packer_top.sv
// path: the job of an input beat is written into the job queue, and its bytes
// then pass one per cycle into the result register while it is free or popped
// throughput: one input beat per cycle while the job queue has room; the
// byte serializer emits one byte per cycle while the receiver keeps popping
// reset: asynchronous, active low; clears waiting bits, bit counter, job
// queue and the valid flag of the result register
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_top
// Packs variable-width codes lsb first into bytes, with optional zero-padded
// flush of the partial byte and a saturating count of bits written.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [lbp_pkg::VALUE_W-1:0]    value_i,
  input  logic [lbp_pkg::NCOUNT_W-1:0]   bit_count_i,
  input  logic                           finish_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [lbp_pkg::BYTE_BITS-1:0]  out_byte_o,
  output logic [lbp_pkg::OBITS_W-1:0]    out_bits_o,
  output logic                           run_last_o,
  output logic [lbp_pkg::TOTAL_W-1:0]    total_bits_o
);

  lbp_pkg::job_beat_t wr_job;
  lbp_pkg::job_beat_t head_job;
  logic               q_rd;

  lbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .q_full_i    (full),
    .value_i     (value_i),
    .bit_count_i (bit_count_i),
    .finish_i    (finish_i),
    .job_o       (wr_job)
  );

  lbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr_job),
    .full_o (full),
    .rd_i   (q_rd),
    .head_o (head_job)
  );

  lbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .q_rd_o       (q_rd),
    .pop          (pop),
    .empty        (empty),
    .out_byte_o   (out_byte_o),
    .out_bits_o   (out_bits_o),
    .run_last_o   (run_last_o),
    .total_bits_o (total_bits_o)
  );

endmodule

// File: verif/lbp_byte_stream_pkg.sv
// ----------------------------------------------------------------------------
// lbp_byte_stream_pkg
// Tracks the byte stream that the lsb-first bit packer should produce:
// mirrors the waiting bits and the saturating bit count, queues the bytes
// each accepted code beat should yield, and checks every popped byte
// against the oldest one in the queue.
// ----------------------------------------------------------------------------
package lbp_byte_stream_pkg;

  import lbp_pkg::*;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic [OBITS_W-1:0]   nbits;
    logic                 last;
    logic [TOTAL_W-1:0]   total;
  } packed_byte_t;

  class byte_stream_tracker;

    logic [PEND_W-1:0]     pend_bits;
    logic [PCNT_W-1:0]     pend_fill;
    logic [COUNT_BITS-1:0] bits_written;
    packed_byte_t          bytes_due[$];
    int unsigned           mismatches;

    function new();
      pend_bits    = '0;
      pend_fill    = '0;
      bits_written = '0;
      mismatches   = 0;
    endfunction

    function void take_code(input logic [VALUE_W-1:0] value,
                            input logic [NCOUNT_W-1:0] count,
                            input logic finish);
      int unsigned            n;
      int unsigned            fill;
      logic [BYTE_BITS-1:0]   acc;
      logic [COUNT_BITS:0]    sum;
      packed_byte_t           one;
      packed_byte_t           made[$];
      n    = (count > MAX_CODE_BITS) ? MAX_CODE_BITS : count;
      acc  = {1'b0, pend_bits};
      fill = pend_fill;
      for (int i = 0; i < n; i++) begin
        acc[fill] = value[i];
        fill++;
        if (fill == BYTE_BITS) begin
          one       = '0;
          one.data  = acc;
          one.nbits = OBITS_W'(BYTE_BITS);
          made.push_back(one);
          acc  = '0;
          fill = 0;
        end
      end
      if (finish && fill != 0) begin
        one       = '0;
        one.data  = acc;
        one.nbits = OBITS_W'(fill);
        made.push_back(one);
        acc  = '0;
        fill = 0;
      end
      // saturating count, padding not included
      sum          = {1'b0, bits_written} + (COUNT_BITS + 1)'(n);
      bits_written = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      pend_bits    = acc[PEND_W-1:0];
      pend_fill    = PCNT_W'(fill);
      foreach (made[j]) begin
        made[j].total = bits_written[TOTAL_W-1:0];
        made[j].last  = (j == made.size() - 1);
        bytes_due.push_back(made[j]);
      end
    endfunction

    function void match_byte(input logic [BYTE_BITS-1:0] data,
                             input logic [OBITS_W-1:0] nbits,
                             input logic last,
                             input logic [TOTAL_W-1:0] total);
      packed_byte_t want;
      if (bytes_due.size() == 0) begin
        $error("byte beat with nothing expected: out_byte %h out_bits %0d", data, nbits);
        mismatches++;
        return;
      end
      want = bytes_due.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %h, actual %h", want.data, data);
        mismatches++;
      end
      if (nbits !== want.nbits) begin
        $error("out_bits: expected %0d, actual %0d", want.nbits, nbits);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("run_last: expected %b, actual %b", want.last, last);
        mismatches++;
      end
      if (total !== want.total) begin
        $error("total_bits: expected %0d, actual %0d", want.total, total);
        mismatches++;
      end
    endfunction

  endclass

endpackage

// File: verif/tb_lsb_first_bit_packer_top.sv
// ----------------------------------------------------------------------------
// tb_lsb_first_bit_packer_top
// Drives code beats into the bit packer and pops its bytes under random
// idling on both sides, including a long receiver hold-off that backs the
// block up. Every popped byte is checked field by field against a tracker
// that rebuilds the byte stream from the accepted code beats.
// ----------------------------------------------------------------------------
module tb_lsb_first_bit_packer_top;

  timeunit 1ns;
  timeprecision 1ps;

  import lbp_pkg::*;
  import lbp_byte_stream_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned PHASE_ITEMS  = 70;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [VALUE_W-1:0]    value_i;
  logic [NCOUNT_W-1:0]   bit_count_i;
  logic                  finish_i;
  logic                  empty;
  logic                  pop;
  logic [BYTE_BITS-1:0]  out_byte_o;
  logic [OBITS_W-1:0]    out_bits_o;
  logic                  run_last_o;
  logic [TOTAL_W-1:0]    total_bits_o;

  int unsigned           send_idle_pct = 18;
  int unsigned           recv_idle_pct = 81;
  bit                    hold_off_req  = 1'b0;
  int unsigned           stall_cycles  = 0;
  byte_stream_tracker    tracker       = new();

  lsb_first_bit_packer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .value_i      (value_i),
    .bit_count_i  (bit_count_i),
    .finish_i     (finish_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .out_bits_o   (out_bits_o),
    .run_last_o   (run_last_o),
    .total_bits_o (total_bits_o)
  );

  always #5ns clk_i = ~clk_i;

  function automatic logic [VALUE_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic offer_code(input logic [VALUE_W-1:0] v, input logic [NCOUNT_W-1:0] n,
                            input logic f);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    value_i     <= v;
    bit_count_i <= n;
    finish_i    <= f;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic offer_random_code();
    int unsigned      kind;
    logic [NCOUNT_W-1:0] n;
    kind = $urandom_range(99);
    if (kind < 70) begin
      n = NCOUNT_W'($urandom_range(16, 9));
    end else if (kind < 85) begin
      n = NCOUNT_W'($urandom_range(8, 0));
    end else if (kind < 95) begin
      n = NCOUNT_W'($urandom_range(64, 17));
    end else begin
      n = NCOUNT_W'($urandom_range(127, 65));
    end
    offer_code(rand_word(), n, $urandom_range(99) < 12);
  endtask

  // beat monitor, sampled at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else begin
      if (push && !full) begin
        tracker.take_code(value_i, bit_count_i, finish_i);
      end
      if (pop && !empty) begin
        tracker.match_byte(out_byte_o, out_bits_o, run_last_o, total_bits_o);
      end
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // receiver
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    value_i     = '0;
    bit_count_i = '0;
    finish_i    = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero count, flush with nothing waiting, partial flush
    offer_code('0, 0, 1'b0);
    offer_code('0, 0, 1'b1);
    offer_code(64'h5, 3, 1'b0);
    offer_code(rand_word(), 0, 1'b1);
    // widest codes and oversized counts
    offer_code('1, 64, 1'b0);
    offer_code('0, 64, 1'b1);
    offer_code(64'h8000_0000_0000_0000, 64, 1'b0);
    offer_code(rand_word(), 127, 1'b0);
    offer_code(rand_word(), 65, 1'b1);
    offer_code(rand_word(), 100, 1'b0);
    offer_code('1, 127, 1'b1);
    // byte boundaries
    offer_code(64'hA5, 8, 1'b0);
    offer_code('1, 1, 1'b0);
    offer_code(64'h7F, 7, 1'b1);
    offer_code(rand_word(), 1, 1'b1);
    // seven bits waiting plus a full code gives the most bytes
    offer_code(rand_word(), 7, 1'b0);
    offer_code(rand_word(), 64, 1'b1);
    offer_code(rand_word(), 9, 1'b0);
    offer_code(rand_word(), 16, 1'b0);
    offer_code(rand_word(), 13, 1'b1);

    repeat (PHASE_ITEMS) offer_random_code();
    send_idle_pct = 81;
    recv_idle_pct = 18;
    repeat (PHASE_ITEMS) offer_random_code();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 1'b1;
    repeat (PHASE_ITEMS) offer_random_code();
    @(negedge clk_i);
    push <= 1'b0;

    while (tracker.bytes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
